/* rtl/msfp_pkg.sv */
// Shared types and constants for the motor status frame parser.
// No dependencies; imported by msfp_frame_check and motor_status_frame_parser.
package msfp_pkg;

   localparam logic [7:0] SYNC_BYTE     = 8'h3E;
   localparam logic [7:0] CR_BYTE       = 8'h0D;
   localparam logic [7:0] LF_BYTE       = 8'h0A;
   localparam logic [7:0] REPLY_CMD_RST = 8'h9C;

   // frame positions; count saturates at FRAME_MIN
   localparam int         PAYLOAD_LEN  = 7;
   localparam logic [3:0] FRAME_MIN    = 4'd13;
   localparam logic [3:0] POS_SYNC     = 4'd0;
   localparam logic [3:0] POS_CMD      = 4'd1;
   localparam logic [3:0] POS_ID       = 4'd2;
   localparam logic [3:0] POS_HEAD_END = 4'd3;
   localparam logic [3:0] POS_HEAD_SUM = 4'd4;
   localparam logic [3:0] POS_PAYLOAD  = 4'd5;
   localparam logic [3:0] POS_BODY_END = 4'd11;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_HEADER    = 3'd2,
      STATUS_HEAD_SUM  = 3'd3,
      STATUS_BODY_SUM  = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  motor_id;
      logic [7:0]  temperature;
      logic [15:0] torque_current;
      logic [15:0] shaft_speed;
      logic [15:0] encoder_position;
   } result_type;

endpackage

/* rtl/msfp_frame_check.sv */
// Running frame checker: CR hold-back, byte position, checksums, id and payload capture.
// Depends on msfp_pkg.
module msfp_frame_check
   import msfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   input  logic [7:0] reply_command,
   output logic       emit,
   output result_type result
);

   typedef struct packed {
      logic [3:0] count;
      logic [7:0] head_sum;
      logic [7:0] body_sum;
      logic       header_bad;
      logic       head_sum_bad;
      logic       body_sum_bad;
   } frame_type;

   function automatic frame_type absorb(frame_type s, logic [7:0] b, logic [7:0] cmd);
      frame_type n;
      n = s;
      if (s.count < FRAME_MIN) begin
         if (s.count == POS_SYNC && b != SYNC_BYTE) n.header_bad = 1'b1;
         if (s.count == POS_CMD && b != cmd) n.header_bad = 1'b1;
         if (s.count <= POS_HEAD_END) begin
            n.head_sum = s.head_sum + b;
         end else if (s.count == POS_HEAD_SUM) begin
            if (b != s.head_sum) n.head_sum_bad = 1'b1;
         end else if (s.count <= POS_BODY_END) begin
            n.body_sum = s.body_sum + b;
         end else begin
            if (b != s.body_sum) n.body_sum_bad = 1'b1;
         end
         n.count = s.count + 4'd1;
      end
      return n;
   endfunction

   logic       cr_held_ff, cr_held_in;
   frame_type  frame_ff, frame_in;
   logic [7:0] id_ff;
   logic [7:0] payload_ff [PAYLOAD_LEN];

   logic       is_cr, is_lf;
   logic       a_en, b_en;
   frame_type  frame_a, frame_b;

   assign is_cr = (rx_byte == CR_BYTE);
   assign is_lf = (rx_byte == LF_BYTE);
   assign emit  = cr_held_ff && is_lf;

   // a held CR that is not followed by LF is data; it goes in ahead of the new byte
   assign a_en = step_en && cr_held_ff && !is_lf;
   assign b_en = step_en && !emit && !is_cr;

   always_comb begin
      frame_a    = a_en ? absorb(frame_ff, CR_BYTE, reply_command) : frame_ff;
      frame_b    = b_en ? absorb(frame_a, rx_byte, reply_command) : frame_a;
      frame_in   = emit ? '0 : frame_b;
      cr_held_in = is_cr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_held_ff <= 1'b0;
         frame_ff   <= '0;
         id_ff      <= '0;
      end else if (step_en) begin
         cr_held_ff <= cr_held_in;
         frame_ff   <= frame_in;
         if (b_en && frame_a.count == POS_ID) begin
            id_ff <= rx_byte;
         end else if (a_en && frame_ff.count == POS_ID) begin
            id_ff <= CR_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
         if (b_en && frame_a.count == POS_PAYLOAD + 4'(k)) begin
            payload_ff[k] <= rx_byte;
         end else if (a_en && frame_ff.count == POS_PAYLOAD + 4'(k)) begin
            payload_ff[k] <= CR_BYTE;
         end
      end
   end

   always_comb begin
      result = '0;
      if (frame_ff.count < FRAME_MIN) begin
         result.status = STATUS_SHORT;
      end else if (frame_ff.header_bad) begin
         result.status = STATUS_HEADER;
      end else if (frame_ff.head_sum_bad) begin
         result.status = STATUS_HEAD_SUM;
      end else if (frame_ff.body_sum_bad) begin
         result.status = STATUS_BODY_SUM;
      end else begin
         result.status           = STATUS_OK;
         result.motor_id         = id_ff;
         result.temperature      = payload_ff[0];
         result.torque_current   = {payload_ff[2], payload_ff[1]};
         result.shaft_speed      = {payload_ff[4], payload_ff[3]};
         result.encoder_position = {payload_ff[6], payload_ff[5]};
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff.count <= FRAME_MIN)
      else $error("byte count past saturation");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && emit |=> frame_ff.count == 4'd0 && !cr_held_ff)
      else $error("frame state not cleared after terminator");

   a_ok_full: assert property (@(posedge clock) disable iff (reset)
      result.status == STATUS_OK |-> frame_ff.count == FRAME_MIN)
      else $error("ok status on a short frame");

endmodule

/* rtl/motor_status_frame_parser.sv */
// Top level of the motor status frame parser: input register, checker, result register.
// Depends on msfp_pkg and msfp_frame_check.
//
// Takes one received link byte per clock on the req_ channel, unless a result
// waits unread, and gives one rsp_ transfer per frame, when the CR LF terminator
// completes. Throughput is one byte per clock while no result waits unread, set
// by a single register-to-register pass: the byte is registered on entry, the
// frame checker updates its running sums and flags from it, and a completed
// frame's result is registered for rsp_ once the input register passes on its LF.
// While a result waits unread, the input register takes at most one more byte
// and then stalls until the rsp_ transfer frees the result register. Status
// 0 is ok; 1 too short, 2 bad header, 3 bad header sum, 4 bad data sum, in that
// priority; on any error the data fields read zero. csr_wr_data sets the reply
// command byte (reset 0x9C); write it only while no frame is in flight.
module motor_status_frame_parser
   import msfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_motor_id,
   output logic signed [7:0]  rsp_temperature,
   output logic signed [15:0] rsp_torque_current,
   output logic signed [15:0] rsp_shaft_speed,
   output logic [15:0]        rsp_encoder_position,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   logic [7:0] reply_cmd_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       advance;
   logic       emit;
   result_type result;

   // advance the held byte whenever the result slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_cmd_ff <= REPLY_CMD_RST;
      end else if (csr_wr_en) begin
         reply_cmd_ff <= csr_wr_data;
      end
   end

   // input register: hold the byte until the checker takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   msfp_frame_check u_check (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .rx_byte       (in_byte_ff),
      .reply_command (reply_cmd_ff),
      .emit          (emit),
      .result        (result)
   );

   // result register: load on a terminator, drop after the rsp transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_motor_id         = rsp_ff.motor_id;
   assign rsp_temperature      = signed'(rsp_ff.temperature);
   assign rsp_torque_current   = signed'(rsp_ff.torque_current);
   assign rsp_shaft_speed      = signed'(rsp_ff.shaft_speed);
   assign rsp_encoder_position = rsp_ff.encoder_position;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.motor_id == 8'd0 && rsp_ff.temperature == 8'd0 &&
         rsp_ff.torque_current == 16'd0 && rsp_ff.shaft_speed == 16'd0 &&
         rsp_ff.encoder_position == 16'd0)
      else $error("data fields not zero on error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status <= STATUS_BODY_SUM)
      else $error("status code out of range");

   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && emit))
      else $error("result loaded without a terminator");

endmodule
